/* sv/mcma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mcma_pkg;

    // Field widths
    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 16;
    localparam int FILL_W   = 4;
    // Fraction bits of the Q12.4 mean
    localparam int FRAC_W   = 4;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [AVG_W-1:0]  average;
        logic [FILL_W-1:0] fill;
    } out_item_t;

endpackage

`default_nettype wire

/* sv/mcma_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mcma_div #(
    parameter int DW = 20,
    parameter int VW = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    dq_reg, dq_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [VW:0]      shifted;
    logic [VW:0]      diff;
    logic             ge;

    // One step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, dq_reg[DW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[VW-1:0] : shifted[VW-1:0];
        dq_next  = {dq_reg[DW-2:0], ge};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

/* sv/multichannel_moving_average_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Flow: an accepted item is written to its channel's window, that channel's fill samples are
//   read back and summed, and the divider (DIV_W = 16 + clog2(WINDOW+1) bits, 20 by default)
//   divides the sum by fill, where fill is the channel's count after the new sample. Throughput:
//   one item at a time; the window is summed one memory read per cycle, then a bit-serial divide.
// Reset: fill counts and write pointers clear at once; window memory is not cleared.
module multichannel_moving_average_unit #(
    parameter int CHANNELS = 4,
    parameter int WINDOW   = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mcma_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mcma_pkg::out_item_t      out_data
);

    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int NW    = $clog2(WINDOW + 1);
    localparam int SW    = mcma_pkg::SAMPLE_W + NW;
    localparam int DW    = SW + mcma_pkg::FRAC_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WRITE = 7'b0000010,
        S_READ  = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_START = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_LOAD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Per-channel state
    logic [NW-1:0] fill_reg [CHANNELS];
    logic [PW-1:0] ptr_reg  [CHANNELS];

    // Item in flight
    logic [CW-1:0]                 ch_reg;
    logic [mcma_pkg::SAMPLE_W-1:0] smp_reg;
    logic [AW-1:0]                 base_reg;
    logic [NW-1:0]                 n_reg;
    logic [NW-1:0]                 k_reg;
    logic [PW-1:0]                 pos_reg;
    logic [SW-1:0]                 sum_reg;
    logic                          rd_vld_reg;

    // Window memory
    logic [mcma_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [mcma_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic                          mem_we;

    // Output register
    logic                out_valid_reg;
    mcma_pkg::out_item_t out_reg;

    logic          in_fire;
    logic          in_range;
    logic [NW-1:0] cur_fill;
    logic [PW-1:0] cur_ptr;
    logic [NW-1:0] new_fill;
    logic [PW-1:0] ptr_inc;
    logic [PW-1:0] pos_dec;
    logic [NW-1:0] k_inc;
    logic          load_out;

    logic          div_start;
    logic          div_done;
    logic [DW-1:0] div_q;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_range = (32'(in_data.channel) < CHANNELS);

    // Channel state lookup and update values
    always_comb
    begin
        cur_fill = fill_reg[ch_reg];
        cur_ptr  = ptr_reg[ch_reg];
        new_fill = (32'(cur_fill) < WINDOW) ? cur_fill + 1'b1 : cur_fill;
        ptr_inc  = (32'(cur_ptr) == WINDOW - 1) ? '0 : cur_ptr + 1'b1;
        pos_dec  = (pos_reg == '0) ? PW'(WINDOW - 1) : pos_reg - 1'b1;
        k_inc    = k_reg + 1'b1;
        wr_addr  = base_reg + AW'(cur_ptr);
        rd_addr  = base_reg + AW'(pos_reg);
        mem_we   = (state_reg == S_WRITE);
        load_out = (state_reg == S_LOAD) && (!out_valid_reg || out_ready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire && in_range) state_next = S_WRITE;
            S_WRITE: state_next = S_READ;
            S_READ:  if (k_inc == n_reg) state_next = S_DRAIN;
            S_DRAIN: state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_LOAD;
            S_LOAD:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Fill counts and write pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fill_reg[i] <= '0;
                ptr_reg[i]  <= '0;
            end
        end
        else if (state_reg == S_WRITE)
        begin
            fill_reg[ch_reg] <= new_fill;
            ptr_reg[ch_reg]  <= ptr_inc;
        end
    end

    // Item registers and window sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == S_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg   <= CW'(in_data.channel);
            smp_reg  <= in_data.sample;
            base_reg <= AW'(in_data.channel) * AW'(WINDOW);
        end
        if (state_reg == S_WRITE)
        begin
            n_reg   <= new_fill;
            pos_reg <= cur_ptr;
            k_reg   <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (state_reg == S_READ)
            begin
                pos_reg <= pos_dec;
                k_reg   <= k_inc;
            end
            if (rd_vld_reg)
            begin
                sum_reg <= sum_reg + SW'(rd_data_reg);
            end
        end
    end

    // Window memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= smp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // Mean: (sum * 16) / fill
    assign div_start = (state_reg == S_START);

    mcma_div #(
        .DW (DW),
        .VW (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, {mcma_pkg::FRAC_W{1'b0}}}),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.average <= mcma_pkg::AVG_W'(div_q);
            out_reg.fill    <= mcma_pkg::FILL_W'(n_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* sim/moving_average_checker.sv */
`timescale 1ns / 1ps

// Watches every channel of the averaging unit, keeps its own copy of every
// channel's sample history and fill count, and compares each result item with
// the oldest predicted one.
module moving_average_checker #(
    parameter int CHANNELS = 4,
    parameter int WINDOW   = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire mcma_pkg::in_item_t  in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire mcma_pkg::out_item_t out_data,
    output int                       mismatches,
    output int                       awaited
);

    // Newest sample at index 0
    logic [mcma_pkg::SAMPLE_W-1:0] history [CHANNELS][WINDOW];
    int unsigned                   depth [CHANNELS];
    mcma_pkg::out_item_t           expected_means [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Shift the sample in, bump the count, then average the newest samples
    function automatic void absorb_sample(input mcma_pkg::in_item_t item);
        int unsigned         ch;
        int unsigned         total;
        logic [31:0]         quotient;
        mcma_pkg::out_item_t mean;
        ch = 32'(item.channel);
        if (ch >= CHANNELS)
            return;
        for (int k = WINDOW - 1; k > 0; k--)
            history[ch][k] = history[ch][k - 1];
        history[ch][0] = item.sample;
        if (depth[ch] < WINDOW)
            depth[ch]++;
        total = 0;
        for (int k = 0; k < depth[ch]; k++)
            total += 32'(history[ch][k]);
        quotient     = (total << mcma_pkg::FRAC_W) / depth[ch];
        mean.average = quotient[mcma_pkg::AVG_W-1:0];
        mean.fill    = depth[ch][mcma_pkg::FILL_W-1:0];
        expected_means.push_back(mean);
    endfunction

    task automatic check_result(input mcma_pkg::out_item_t got);
        mcma_pkg::out_item_t want;
        if (expected_means.size() == 0)
        begin
            report_mismatch("unexpected result item, average", 32'(got.average), 32'd0);
            return;
        end
        want = expected_means.pop_front();
        if (got.average !== want.average)
            report_mismatch("average", 32'(got.average), 32'(want.average));
        if (got.fill !== want.fill)
            report_mismatch("fill", 32'(got.fill), 32'(want.fill));
    endtask

    // Results are checked before the same edge's input is absorbed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
                depth[c] = 0;
            expected_means.delete();
            awaited <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                absorb_sample(in_data);
            awaited <= expected_means.size();
        end
    end

endmodule

/* sim/multichannel_moving_average_unit_test.sv */
`timescale 1ns / 1ps

module multichannel_moving_average_unit_test;

    localparam int CHANNELS        = 4;
    localparam int WINDOW          = 8;
    localparam int RANDOM_SAMPLES  = 930;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_OFF_START  = 2000;
    localparam int HOLD_OFF_CYCLES = 800;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    mcma_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    mcma_pkg::out_item_t out_data;
    int                  mismatches;
    int                  awaited;
    int                  cycle_count = 0;
    // Set for stretches where the sender never pauses
    bit                  back_to_back = 1'b0;

    always #5 clk = ~clk;

    multichannel_moving_average_unit #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    moving_average_checker #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    // Pause length: mostly none or short, now and then long
    function automatic int idle_length(input bit no_pause);
        int roll;
        if (no_pause)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    // Offer one item and hold it until taken; valid only drops if a pause follows
    task automatic send_sample(input logic [mcma_pkg::CHAN_W-1:0] ch,
                               input logic [mcma_pkg::SAMPLE_W-1:0] smp);
        int gap;
        in_data  <= '{channel: ch, sample: smp};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        gap = idle_length(back_to_back);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multichannel_moving_average_unit_test: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off so the unit backs up
    initial
    begin : drain
        int run_len;
        int stall;
        bit held_long;
        held_long = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run_len = $urandom_range(1, 24);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (!held_long && cycle_count > HOLD_OFF_START)
            begin
                stall     = HOLD_OFF_CYCLES;
                held_long = 1'b1;
            end
            else
                stall = idle_length(1'b0);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int                            roll;
        logic [mcma_pkg::CHAN_W-1:0]   ch;
        logic [mcma_pkg::SAMPLE_W-1:0] smp;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Full scale on one channel: fill climbs to the window size, then holds
        repeat (WINDOW + 1) send_sample(2'd0, 12'hFFF);
        // All zeros from a fresh channel
        repeat (2) send_sample(2'd1, 12'h000);
        // Alternating extremes while warming up
        send_sample(2'd2, 12'hFFF);
        send_sample(2'd2, 12'h000);
        send_sample(2'd2, 12'hFFF);
        // Small values whose mean needs truncating
        send_sample(2'd3, 12'h001);
        send_sample(2'd3, 12'h000);
        send_sample(2'd3, 12'h000);
        // Interleaved channels with mid-scale values
        send_sample(2'd1, 12'h800);
        send_sample(2'd0, 12'h000);
        send_sample(2'd3, 12'h7FF);

        // Random part: extremes weighted up, pauses switched off in stretches
        for (int n = 0; n < RANDOM_SAMPLES; n++)
        begin
            if (n % 60 == 0)
                back_to_back = ($urandom_range(0, 2) == 0);
            roll = $urandom_range(0, 9);
            if (roll == 0)
                smp = '0;
            else if (roll == 1)
                smp = '1;
            else
                smp = mcma_pkg::SAMPLE_W'($urandom_range(0, 4095));
            ch = mcma_pkg::CHAN_W'($urandom_range(0, CHANNELS - 1));
            send_sample(ch, smp);
        end
        in_valid <= 1'b0;

        // Let the last acceptance reach the checker's count, then drain
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("multichannel_moving_average_unit_test: done, clean");
        else
            $display("multichannel_moving_average_unit_test: done, errors");
        $finish;
    end

endmodule
